[src/ais_pkg.sv]
// ----------------------------------------------------------------------------
// ais_pkg
// Types, codes and helpers shared by the ASCII integer scanner modules.
// ----------------------------------------------------------------------------
package ais_pkg;

  // Width of the value field of a result
  localparam int unsigned ValueW = 64;

  // Depth of the queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Radix mode codes
  localparam logic [1:0] RxDec  = 2'd0;
  localparam logic [1:0] RxAuto = 2'd1;
  localparam logic [1:0] RxOct  = 2'd2;
  localparam logic [1:0] RxHex  = 2'd3;

  // Result size codes
  localparam logic [1:0] Size32 = 2'd0;
  localparam logic [1:0] Size16 = 2'd1;
  localparam logic [1:0] Size8  = 2'd2;
  localparam logic [1:0] Size64 = 2'd3;

  // Result status codes
  localparam logic [1:0] StConverted = 2'd0;
  localparam logic [1:0] StNoDigit   = 2'd1;
  localparam logic [1:0] StBadHex    = 2'd2;

  // Configuration register indexes
  localparam logic CfgRadixMode  = 1'b0;
  localparam logic CfgResultSize = 1'b1;

  // Characters of interest
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChSeven   = 8'h37;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpA     = 8'h41;
  localparam logic [7:0] ChUpF     = 8'h46;
  localparam logic [7:0] ChUpZ     = 8'h5a;
  localparam logic [7:0] ChLoA     = 8'h61;
  localparam logic [7:0] ChLoF     = 8'h66;
  localparam logic [7:0] ChLoX     = 8'h78;
  localparam logic [7:0] ChLoZ     = 8'h7a;
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChMinus   = 8'h2d;
  // Offsets that map a hex letter to its digit value
  localparam logic [7:0] UpOffset  = 8'h37;
  localparam logic [7:0] LoOffset  = 8'h57;

  // One request on the input channel
  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } ais_in_t;

  // One request on the output channel
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [1:0]        status;
    logic              char_kept;
  } ais_out_t;

  // Classified character, passed from front to back
  typedef struct packed {
    logic       at_end;
    logic       is_dec;
    logic       is_oct;
    logic       is_hex;
    logic       is_letter;
    logic       is_sign;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic [3:0] digit;
  } ais_class_t;

  // Mask of the bits kept for a result size code
  function automatic logic [ValueW-1:0] size_mask(input logic [1:0] size);
    logic [ValueW-1:0] m;
    m = '0;
    unique case (size)
      Size32:  m[31:0] = '1;
      Size16:  m[15:0] = '1;
      Size8:   m[7:0]  = '1;
      default: m       = '1;
    endcase
    return m;
  endfunction

endpackage

[src/ais_front.sv]
// ----------------------------------------------------------------------------
// ais_front
// Accepts input requests and classifies each character for the back end.
// ----------------------------------------------------------------------------
module ais_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ais_pkg::ais_in_t    in_data_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output ais_pkg::ais_class_t q_class_o
);
  import ais_pkg::*;

  logic       live;
  logic       dec;
  logic       lower;
  logic       upper;
  logic       lo_hex;
  logic       up_hex;
  logic [7:0] ch;
  logic [7:0] diff;

  // Stall while the queue has no free entry
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Classify the character; the end mark carries no character
  always_comb begin
    ch     = in_data_i.ch;
    live   = !in_data_i.at_end;
    dec    = (ch >= ChZero) && (ch <= ChNine);
    lower  = (ch >= ChLoA) && (ch <= ChLoZ);
    upper  = (ch >= ChUpA) && (ch <= ChUpZ);
    lo_hex = (ch >= ChLoA) && (ch <= ChLoF);
    up_hex = (ch >= ChUpA) && (ch <= ChUpF);

    if (dec) begin
      diff = ch - ChZero;
    end else if (lower) begin
      diff = ch - LoOffset;
    end else begin
      diff = ch - UpOffset;
    end

    q_class_o.at_end    = in_data_i.at_end;
    q_class_o.is_dec    = live && dec;
    q_class_o.is_oct    = live && (ch >= ChZero) && (ch <= ChSeven);
    q_class_o.is_hex    = live && (dec || lo_hex || up_hex);
    q_class_o.is_letter = live && (lower || upper);
    q_class_o.is_sign   = live && ((ch == ChPlus) || (ch == ChMinus));
    q_class_o.is_minus  = live && (ch == ChMinus);
    q_class_o.is_zero   = live && (ch == ChZero);
    q_class_o.is_x      = live && (ch == ChLoX);
    q_class_o.digit     = diff[3:0];
  end

endmodule

[src/ais_queue.sv]
// ----------------------------------------------------------------------------
// ais_queue
// Short queue of classified characters between front and back.
// ----------------------------------------------------------------------------
module ais_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ais_pkg::ais_class_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ais_pkg::ais_class_t pop_data_o
);
  import ais_pkg::*;

  ais_class_t       mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o     = (count_q == QCntW'(QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries; no reset needed for payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/ais_back.sv]
// ----------------------------------------------------------------------------
// ais_back
// Scanning state machine, accumulator and output register.
// ----------------------------------------------------------------------------
module ais_back #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          radix_mode_i,
  input  logic [1:0]          result_size_i,
  input  logic                q_valid_i,
  input  ais_pkg::ais_class_t q_class_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ais_pkg::ais_out_t   out_data_o
);
  import ais_pkg::*;

  localparam logic [2:0] PhStart  = 3'd0;
  localparam logic [2:0] PhSigned = 3'd1;
  localparam logic [2:0] PhZero   = 3'd2;
  localparam logic [2:0] PhZeroX  = 3'd3;
  localparam logic [2:0] PhDigits = 3'd4;

  logic [2:0]            phase_q, phase_d;
  logic                  neg_q, neg_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [1:0]            arx_q, arx_d;

  logic                  out_valid_q;
  ais_out_t              out_q;

  logic                  emit;
  logic                  emit_ok;
  logic [1:0]            emit_status;
  logic                  emit_kept;
  logic                  act_digit;
  logic                  out_free;
  logic [VALUE_BITS-1:0] dig_ext;
  logic [VALUE_BITS-1:0] acc_next;
  logic [VALUE_BITS-1:0] signed_v;
  logic [ValueW-1:0]     value_ext;
  ais_class_t            c;

  assign c       = q_class_i;
  assign dig_ext = VALUE_BITS'(c.digit);

  // Digit test and shift-add accumulate in the latched radix
  always_comb begin
    case (arx_q)
      RxOct: begin
        act_digit = c.is_oct;
        acc_next  = (acc_q << 3) + dig_ext;
      end
      RxHex: begin
        act_digit = c.is_hex;
        acc_next  = (acc_q << 4) + dig_ext;
      end
      default: begin
        act_digit = c.is_dec;
        acc_next  = (acc_q << 3) + (acc_q << 1) + dig_ext;
      end
    endcase
  end

  // Next state for the character at the head of the queue
  always_comb begin
    phase_d     = phase_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    arx_d       = arx_q;
    emit        = 1'b0;
    emit_ok     = 1'b0;
    emit_status = StConverted;
    emit_kept   = 1'b0;

    unique case (phase_q)
      PhZero: begin
        if (c.is_x) begin
          phase_d = PhZeroX;
        end else if (c.is_oct) begin
          arx_d   = RxOct;
          acc_d   = dig_ext;
          phase_d = PhDigits;
        end else if (c.is_dec) begin
          arx_d   = RxDec;
          acc_d   = dig_ext;
          phase_d = PhDigits;
        end else begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_kept = !c.at_end;
        end
      end
      PhZeroX: begin
        if (c.is_hex) begin
          arx_d   = RxHex;
          acc_d   = dig_ext;
          phase_d = PhDigits;
        end else begin
          emit        = 1'b1;
          emit_status = StBadHex;
        end
      end
      PhDigits: begin
        if (act_digit) begin
          acc_d = acc_next;
        end else begin
          emit      = 1'b1;
          emit_ok   = 1'b1;
          emit_kept = !c.at_end;
        end
      end
      default: begin
        // Start, after a sign, and unused codes: the first digit is due
        if (phase_q != PhSigned && c.is_sign && radix_mode_i != RxOct) begin
          neg_d   = c.is_minus;
          phase_d = PhSigned;
        end else if (c.at_end) begin
          emit        = 1'b1;
          emit_status = StNoDigit;
        end else begin
          case (radix_mode_i)
            RxAuto: begin
              if (c.is_zero) begin
                acc_d   = '0;
                phase_d = PhZero;
              end else if (c.is_dec) begin
                arx_d   = RxDec;
                acc_d   = dig_ext;
                phase_d = PhDigits;
              end else begin
                emit        = 1'b1;
                emit_status = StNoDigit;
                emit_kept   = 1'b1;
              end
            end
            RxHex: begin
              if (c.is_hex) begin
                arx_d   = RxHex;
                acc_d   = dig_ext;
                phase_d = PhDigits;
              end else if (c.is_letter) begin
                // A non-hex letter reads as zero and is handed back
                emit      = 1'b1;
                emit_kept = 1'b1;
              end else begin
                emit        = 1'b1;
                emit_status = StNoDigit;
                emit_kept   = 1'b1;
              end
            end
            default: begin
              if ((radix_mode_i == RxOct) ? c.is_oct : c.is_dec) begin
                arx_d   = radix_mode_i;
                acc_d   = dig_ext;
                phase_d = PhDigits;
              end else begin
                emit        = 1'b1;
                emit_status = StNoDigit;
                emit_kept   = 1'b1;
              end
            end
          endcase
        end
      end
    endcase

    // Restart after every result
    if (emit) begin
      phase_d = PhStart;
      neg_d   = 1'b0;
      acc_d   = '0;
      arx_d   = RxDec;
    end
  end

  // Negate, widen and cut to the selected size
  always_comb begin
    signed_v  = neg_q ? ('0 - acc_q) : acc_q;
    value_ext = '0;
    value_ext[VALUE_BITS-1:0] = signed_v;
    value_ext = value_ext & size_mask(result_size_i);
  end

  // Pop when the item needs no output slot or one is free
  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = q_valid_i && (!emit || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStart;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      arx_q   <= RxDec;
    end else if (q_pop_o) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      arx_q   <= arx_d;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && emit) begin
      out_q.value     <= emit_ok ? value_ext : '0;
      out_q.status    <= emit_status;
      out_q.char_kept <= emit_kept;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/ascii_integer_scanner_core.sv]
// ----------------------------------------------------------------------------
// ascii_integer_scanner_core
// Scans one integer from a stream of ASCII characters in decimal, auto,
// octal or hex notation and returns it with a status per number.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+----------------------
//  in       | input     | in_valid_i / in_stall_o    | ais_in_t  (ch, at_end)
//  out      | output    | out_valid_o / out_stall_i  | ais_out_t (value,
//           |           |                            |  status, char_kept)
//  cfg      | input     | cfg_we_i, cfg_idx_i        | cfg_wdata_i
//
//  One character per cycle while the queue has room; the character ending a
//  number is queued, then its result goes to the output register. The state
//  machine and shift-add accumulator in the back end take one queued character
//  per cycle while no result is stalled; the two-entry queue absorbs output
//  stalls. Reset clears the queue, the scanning state and the configuration
//  at once. A stalled output holds; input stalls only once the queue is full.
// ----------------------------------------------------------------------------
module ascii_integer_scanner_core #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ais_pkg::ais_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ais_pkg::ais_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [1:0]        cfg_wdata_i
);
  import ais_pkg::*;

  logic [1:0] radix_q;
  logic [1:0] size_q;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  ais_class_t push_class;
  ais_class_t head_class;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RxDec;
      size_q  <= Size32;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgRadixMode:  radix_q <= cfg_wdata_i;
        default:       size_q  <= cfg_wdata_i;
      endcase
    end
  end

  ais_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_class_o  (push_class)
  );

  ais_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_class),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (head_class)
  );

  ais_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radix_mode_i  (radix_q),
    .result_size_i (size_q),
    .q_valid_i     (q_valid),
    .q_class_i     (head_class),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

[src/ais_checker.sv]
// ----------------------------------------------------------------------------
// ais_checker
// Port-level checks on the ASCII integer scanner, bound to the top level.
// ----------------------------------------------------------------------------
module ais_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ais_pkg::ais_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ais_pkg::ais_out_t out_data_o,
  input logic              cfg_we_i,
  input logic              cfg_idx_i,
  input logic [1:0]        cfg_wdata_i
);
  import ais_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // Failed conversions carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != StConverted |-> out_data_o.value == '0)
    else $error("failed conversion with non-zero value");

  // Bad hex consumes its character, and no other status code appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == StBadHex |-> !out_data_o.char_kept)
    else $error("bad hex result hands back its character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status == StConverted
                 || out_data_o.status == StNoDigit
                 || out_data_o.status == StBadHex)
    else $error("unknown status code");

endmodule

bind ascii_integer_scanner_core ais_checker u_ais_checker (.*);
